// ===== hw/rtl/sst_pkg.sv =====
// Shared types and constants for the set span tracker.
// Used by sst_cell, set_span_tracker, sst_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sst_pkg;

   // Store depth and the widths that follow from it.
   localparam int MAX_CAPACITY = 64;
   localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
   localparam int VAL_W        = 32;
   localparam int GAP_W        = VAL_W + 1;
   localparam int CAP_W        = 7;

   localparam logic [GAP_W-1:0] GAP_ALL_ONES = {GAP_W{1'b1}};

   // Status codes of a result.
   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_REFUSED  = 1'b1;

   // A number travelling along the chain of cells.
   typedef struct packed {
      logic                    vld;
      logic signed [VAL_W-1:0] value;
      logic [GAP_W-1:0]        gap;
      logic [CNT_W-1:0]        left;
   } token_type;

   // Report of the cell that stored the travelling number.
   typedef struct packed {
      logic             vld;
      logic [GAP_W-1:0] gap;
   } done_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/set_span_tracker.sv =====
// Top level of the set span tracker: control, span registers and the cell chain.
// Depends on sst_pkg and sst_cell.
`timescale 1ns / 1ps

// Usage:
// A transaction is accepted at a rising edge where start is high and busy is
// low; req_restart empties the store before req_value is added. Each
// transaction gives exactly one result, shown for one cycle with rsp_strobe.
// The receiver cannot stall; the result is simply taken in that cycle.
// csr_wr_en writes csr_wr_data into the capacity register; write it only
// while busy is low. Capacities above the store depth act as the depth.
// The held numbers sit in a chain of cells, and an accepted number
// walks the chain one cell a cycle until it reaches the first free cell,
// where it is stored. That cell's report moves the control to the result
// state, where rsp_strobe is high; busy falls at the edge that ends it.
// A refused number does not enter the chain: its result is shown in the
// cycle right after acceptance.
// Reset (synchronous, active high) empties the store, sets the capacity to
// zero and returns to idle; no result is pending after reset.

module set_span_tracker
   import sst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_restart,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [CAP_W-1:0]        csr_wr_data,
   output logic                    rsp_strobe,
   output logic                    rsp_status,
   output logic                    rsp_span_valid,
   output logic [VAL_W-1:0]        rsp_shortest_span,
   output logic [VAL_W-1:0]        rsp_longest_span,
   output logic [CAP_W-1:0]        rsp_held_count
);

   localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   state_type               state_ff, state_in;
   logic [CAP_W-1:0]        cap_ff;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [GAP_W-1:0]        gap_ff, gap_in;
   logic signed [VAL_W-1:0] min_ff, min_in, max_ff, max_in;
   logic                    status_ff, status_in;

   logic                    accept;
   logic [LIM_W-1:0]        limit;
   logic [CNT_W-1:0]        eff_held;
   logic [GAP_W-1:0]        eff_gap;
   logic signed [VAL_W-1:0] eff_min, eff_max;
   logic                    refuse;
   token_type               inject;
   token_type               tok_link [MAX_CAPACITY];
   done_type                done_cell [MAX_CAPACITY];
   logic                    done_any;
   logic [GAP_W-1:0]        done_gap;
   logic signed [GAP_W-1:0] range_wide;
   logic                    valid;

   assign accept = start && (state_ff == ST_IDLE);

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Store state as seen by a new transaction, after an optional restart.
   always_comb begin
      limit    = (LIM_W'(cap_ff) > LIM_W'(MAX_CAPACITY)) ? LIM_W'(MAX_CAPACITY)
                                                         : LIM_W'(cap_ff);
      eff_held = req_restart ? '0 : held_ff;
      eff_gap  = req_restart ? GAP_ALL_ONES : gap_ff;
      eff_min  = req_restart ? '0 : min_ff;
      eff_max  = req_restart ? '0 : max_ff;
      refuse   = (LIM_W'(eff_held) >= limit);
   end

   // Token that enters the first cell.
   always_comb begin
      inject.vld   = accept && !refuse;
      inject.value = req_value;
      inject.gap   = eff_gap;
      inject.left  = eff_held;
   end

   // Chain of cells.
   for (genvar i = 0; i < MAX_CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         sst_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (inject),
            .tok_out (tok_link[i]),
            .done    (done_cell[i])
         );
      end else begin : g_body
         sst_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok_link[i-1]),
            .tok_out (tok_link[i]),
            .done    (done_cell[i])
         );
      end
   end

   // At most one cell reports in a cycle, so an OR merges the reports.
   always_comb begin
      done_any = 1'b0;
      done_gap = '0;
      for (int i = 0; i < MAX_CAPACITY; i++) begin
         done_any = done_any | done_cell[i].vld;
         done_gap = done_gap | (done_cell[i].gap & {GAP_W{done_cell[i].vld}});
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = refuse ? ST_RESP : ST_RUN;
            end
         end
         ST_RUN: begin
            if (done_any) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Span and count registers.
   always_comb begin
      held_in   = held_ff;
      gap_in    = gap_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      status_in = status_ff;
      if (accept) begin
         held_in   = refuse ? eff_held : eff_held + CNT_W'(1);
         gap_in    = eff_gap;
         status_in = refuse ? STATUS_REFUSED : STATUS_ACCEPTED;
         min_in    = eff_min;
         max_in    = eff_max;
         if (!refuse) begin
            if (eff_held == '0) begin
               min_in = req_value;
               max_in = req_value;
            end else begin
               if (req_value < eff_min) min_in = req_value;
               if (req_value > eff_max) max_in = req_value;
            end
         end
      end else if (state_ff == ST_RUN && done_any) begin
         gap_in = done_gap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         held_ff   <= '0;
         gap_ff    <= GAP_ALL_ONES;
         min_ff    <= '0;
         max_ff    <= '0;
         status_ff <= STATUS_ACCEPTED;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         gap_ff    <= gap_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         status_ff <= status_in;
      end
   end

   // Outputs.
   always_comb begin
      range_wide        = {max_ff[VAL_W-1], max_ff} - {min_ff[VAL_W-1], min_ff};
      valid             = (held_ff >= CNT_W'(2));
      busy              = (state_ff != ST_IDLE);
      rsp_strobe        = (state_ff == ST_RESP);
      rsp_status        = status_ff;
      rsp_span_valid    = valid;
      rsp_shortest_span = valid ? gap_ff[VAL_W-1:0] : '0;
      rsp_longest_span  = valid ? range_wide[VAL_W-1:0] : '0;
      rsp_held_count    = CAP_W'(held_ff);
   end

endmodule

// ===== hw/rtl/sst_cell.sv =====
// One cell of the store chain: holds one number and compares passing numbers with it.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell
   import sst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out,
   output done_type  done
);

   token_type               tok_ff;
   logic signed [VAL_W-1:0] held_ff;
   logic signed [GAP_W-1:0] diff;
   logic [GAP_W-1:0]        gap_here;
   logic                    occupied;

   // The token moves one cell along the chain in every cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff.vld <= tok_in.vld;
      end
      tok_ff.value <= tok_in.value;
      tok_ff.gap   <= tok_in.gap;
      tok_ff.left  <= tok_in.left;
   end

   // A cell with no held entries left ahead of it is the first free one.
   assign occupied = (tok_ff.left != '0);

   // Distance between the passing number and the held one.
   always_comb begin
      diff     = {tok_ff.value[VAL_W-1], tok_ff.value} - {held_ff[VAL_W-1], held_ff};
      gap_here = diff[GAP_W-1] ? GAP_W'(-diff) : GAP_W'(diff);
   end

   // The free cell takes the number; an occupied cell passes it on.
   always_comb begin
      tok_out       = tok_ff;
      tok_out.vld   = tok_ff.vld && occupied;
      tok_out.gap   = (gap_here < tok_ff.gap) ? gap_here : tok_ff.gap;
      tok_out.left  = tok_ff.left - CNT_W'(1);
      done.vld      = tok_ff.vld && !occupied;
      done.gap      = tok_ff.gap;
   end

   always_ff @(posedge clock) begin
      if (done.vld) begin
         held_ff <= tok_ff.value;
      end
   end

endmodule

// ===== hw/rtl/sst_checker.sv =====
// Port-level checks for the set span tracker, bound to the top level.
// Depends on sst_pkg and set_span_tracker.
`timescale 1ns / 1ps

module sst_checker
   import sst_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic             rsp_span_valid,
   input logic [VAL_W-1:0] rsp_shortest_span,
   input logic [VAL_W-1:0] rsp_longest_span,
   input logic [CAP_W-1:0] rsp_held_count
);

   // An accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a transaction");

   // A result is shown while the transaction is still open.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a transaction");

   // One result per transaction, one cycle wide.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe longer than one cycle");

   // Spans are zero when fewer than two numbers are held.
   a_spans_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_span_valid |->
         rsp_shortest_span == '0 && rsp_longest_span == '0)
      else $error("spans reported without two held numbers");

   // Valid spans need at least two numbers and shortest never exceeds longest.
   a_spans_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_span_valid |->
         rsp_held_count >= CAP_W'(2) && rsp_shortest_span <= rsp_longest_span)
      else $error("inconsistent valid spans");

endmodule

bind set_span_tracker sst_checker u_sst_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_span_valid    (rsp_span_valid),
   .rsp_shortest_span (rsp_shortest_span),
   .rsp_longest_span  (rsp_longest_span),
   .rsp_held_count    (rsp_held_count)
);

// ===== bench/set_span_tracker_tb.sv =====
// Self-checking testbench for the set span tracker: directed and random transactions
// against a behavioural model of the span registers. Depends on sst_pkg and set_span_tracker.
`timescale 1ns / 1ps

module set_span_tracker_tb;
   import sst_pkg::*;

   // Cycles without any handshake before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = MAX_CAPACITY + 16;
   localparam logic [VAL_W-1:0] INT_MIN_VAL = 32'h8000_0000;
   localparam logic [VAL_W-1:0] INT_MAX_VAL = 32'h7FFF_FFFF;

   typedef struct packed {
      logic             status;
      logic             span_valid;
      logic [VAL_W-1:0] shortest;
      logic [VAL_W-1:0] longest;
      logic [CAP_W-1:0] held_count;
   } span_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_restart = 1'b0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    csr_wr_en = 1'b0;
   logic [CAP_W-1:0]        csr_wr_data = '0;
   logic                    rsp_strobe;
   logic                    rsp_status;
   logic                    rsp_span_valid;
   logic [VAL_W-1:0]        rsp_shortest_span;
   logic [VAL_W-1:0]        rsp_longest_span;
   logic [CAP_W-1:0]        rsp_held_count;

   // Model state: the held set, its extremes, the running minimum gap and the capacity.
   logic signed [VAL_W-1:0] held_vals [MAX_CAPACITY];
   int unsigned             held_n = 0;
   logic signed [VAL_W-1:0] low_val = '0;
   logic signed [VAL_W-1:0] high_val = '0;
   logic [GAP_W-1:0]        gap_min = GAP_ALL_ONES;
   logic [CAP_W-1:0]        cap_reg = '0;

   span_result_type pending_spans [$];

   int n_fail     = 0;
   int n_sent     = 0;
   int n_refused  = 0;
   int n_spans    = 0;
   int n_cfg      = 0;
   int max_held   = 0;
   int idle_count = 0;

   set_span_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_restart       (req_restart),
      .req_value         (req_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_span_valid    (rsp_span_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .rsp_held_count    (rsp_held_count)
   );

   // Clock of 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted transaction to the model and returns the expected result.
   function automatic span_result_type predict_spans(input logic restart,
                                                     input logic signed [VAL_W-1:0] v);
      span_result_type r;
      int unsigned     lim;
      longint          d;
      if (restart) begin
         held_n   = 0;
         low_val  = '0;
         high_val = '0;
         gap_min  = GAP_ALL_ONES;
      end
      lim = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : cap_reg;
      r.status = STATUS_ACCEPTED;
      if (held_n >= lim) begin
         r.status = STATUS_REFUSED;
      end else begin
         // The nearest held number gives the new number's contribution to the gap.
         for (int i = 0; i < held_n; i++) begin
            d = longint'(v) - longint'(held_vals[i]);
            if (d < 0) d = -d;
            if (d < longint'(gap_min)) gap_min = d[GAP_W-1:0];
         end
         if (held_n == 0) begin
            low_val  = v;
            high_val = v;
         end else begin
            if (v < low_val) low_val = v;
            if (v > high_val) high_val = v;
         end
         held_vals[held_n] = v;
         held_n++;
      end
      d = longint'(high_val) - longint'(low_val);
      r.span_valid = (held_n >= 2);
      r.shortest   = r.span_valid ? gap_min[VAL_W-1:0] : '0;
      r.longest    = r.span_valid ? d[VAL_W-1:0] : '0;
      r.held_count = held_n[CAP_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      n_fail++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                              input logic [VAL_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   // Result checking, transaction prediction and the watchdog, all at the rising edge.
   always @(posedge clock) begin
      span_result_type want;
      if (!reset) begin
         idle_count++;
         if (rsp_strobe === 1'b1) begin
            idle_count = 0;
            if (pending_spans.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = pending_spans.pop_front();
               check_field("status", VAL_W'(rsp_status), VAL_W'(want.status));
               check_field("span_valid", VAL_W'(rsp_span_valid), VAL_W'(want.span_valid));
               check_field("shortest_span", rsp_shortest_span, want.shortest);
               check_field("longest_span", rsp_longest_span, want.longest);
               check_field("held_count", VAL_W'(rsp_held_count), VAL_W'(want.held_count));
            end
         end
         if (start && !busy) begin
            idle_count = 0;
            want = predict_spans(req_restart, req_value);
            pending_spans = {pending_spans, want};
            n_sent++;
            if (want.status == STATUS_REFUSED) n_refused++;
            if (want.span_valid) n_spans++;
            if (held_n > max_held) max_held = held_n;
         end
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Offers one transaction and holds it until accepted; start drops right afterwards.
   task automatic send_item(input logic restart, input logic signed [VAL_W-1:0] v);
      @(negedge clock);
      start       <= 1'b1;
      req_restart <= restart;
      req_value   <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_spans.size() != 0) @(posedge clock);
   endtask

   // The capacity register is only written with nothing outstanding.
   task automatic write_capacity(input logic [CAP_W-1:0] c);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      cap_reg = c;
      n_cfg++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Capacity is zero after reset, so everything is refused, restart or not.
   task automatic test_reset_capacity();
      send_item(1'b0, 32'sd5);
      send_item(1'b1, -32'sd5);
      write_capacity(7'd0);
      send_item(1'b1, 32'sd0);
   endtask

   // Extremes of the value range, duplicates, a full store and restart on a full store.
   task automatic test_directed_extremes();
      write_capacity(7'd4);
      send_item(1'b1, INT_MIN_VAL);
      send_item(1'b0, INT_MAX_VAL);
      send_item(1'b0, 32'sd0);
      send_item(1'b0, 32'sd0);
      send_item(1'b0, -32'sd1);
      send_item(1'b0, INT_MAX_VAL);
      send_item(1'b1, -32'sd1);
      send_item(1'b0, -32'sd1);
      // A single slot never gives valid spans.
      write_capacity(7'd1);
      send_item(1'b1, 32'sd123);
      send_item(1'b0, 32'sd124);
      write_capacity(7'd2);
      send_item(1'b1, -32'sd1);
      send_item(1'b0, 32'sd1);
      send_item(1'b0, 32'sd0);
      // Capacity above the store depth acts as the depth.
      write_capacity(7'd127);
      send_item(1'b1, 32'sd7);
      send_item(1'b0, 32'sd7);
      send_item(1'b0, INT_MIN_VAL);
   endtask

   function automatic logic [CAP_W-1:0] pick_capacity();
      int unsigned sel;
      sel = $urandom_range(15);
      case (sel)
         0:       return 7'd0;
         1:       return 7'd64;
         2:       return 7'($urandom_range(127, 65));
         3:       return 7'd127;
         default: return 7'($urandom_range(12, 1));
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value(input int mode, input logic [VAL_W-1:0] base);
      case (mode)
         0:       return $urandom;
         1:       return base + $urandom_range(15);
         default: begin
            case ($urandom_range(4))
               0:       return INT_MIN_VAL;
               1:       return INT_MAX_VAL;
               2:       return '0;
               3:       return '1;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Runs of transactions that usually start with a restart and mostly fill the store,
   // with the odd stray restart mixed in and the capacity at times changed between runs.
   task automatic test_random_traffic(input int idle_pct, input int n_items,
                                      input logic [CAP_W-1:0] first_cap);
      int          done;
      int          eff_cap;
      int          run_len;
      int          mode;
      logic [VAL_W-1:0] base;
      logic        restart;
      done = 0;
      write_capacity(first_cap);
      while (done < n_items) begin
         if (done != 0 && $urandom_range(3) == 0) write_capacity(pick_capacity());
         eff_cap = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : cap_reg;
         if ($urandom_range(1) == 0) run_len = eff_cap + $urandom_range(3);
         else run_len = $urandom_range(eff_cap + 3, 1);
         if (run_len == 0) run_len = 1;
         mode = $urandom_range(2);
         base = $urandom;
         for (int k = 0; k < run_len; k++) begin
            while ($urandom_range(99) < idle_pct) @(negedge clock);
            restart = (k == 0) ? ($urandom_range(15) != 0) : ($urandom_range(19) == 0);
            send_item(restart, pick_value(mode, base));
            done++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_capacity();
      test_directed_extremes();
      test_random_traffic(26, 430, 7'd64);
      test_random_traffic(63, 430, 7'd127);
      test_random_traffic(0, 430, 7'($urandom_range(12, 2)));

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d transactions: %0d refused, %0d with valid spans, %0d capacity writes.",
               n_sent, n_refused, n_spans, n_cfg);
      $display("Largest set held was %0d numbers; sender gaps of 26, 63 and 0 percent.",
               max_held);
      if (n_fail == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_cell.sv
hw/rtl/set_span_tracker.sv
hw/rtl/sst_checker.sv
bench/set_span_tracker_tb.sv
